// ===== rtl/ccp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared types and constants for the coefficient compress and pack block.
// ----------------------------------------------------------------------------
package ccp_pkg;

  localparam int COEFF_W   = 13;  // signed coefficient width
  localparam int MODULUS_W = 12;  // modulus register width
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int BYTE_W    = 8;
  localparam int PEND_W    = 7;   // leftover stream bits between items
  localparam int PCNT_W    = 3;
  localparam int QUOT_W    = 5;   // widest compressed word

  // Compression modes
  localparam logic [MODE_W-1:0] MODE_D1  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_D4  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_D5  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RAW = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'b1;

  localparam logic [MODE_W-1:0]    MODE_RESET    = MODE_D4;
  localparam logic [MODULUS_W-1:0] MODULUS_RESET = 12'd3329;

  // Datapath commands from the controller
  typedef struct packed {
    logic load;      // capture item, form numerator
    logic div_step;  // one quotient bit
    logic merge;     // append word to the pending bits
    logic emit;      // move one byte to the output register
    logic finish;    // store leftover bits, close the item
  } dp_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic raw_mode;
    logic div_last;
    logic byte_avail;
    logic out_free;
  } dp_stat_t;

  // Shift amount (word width) for the compressed modes
  function automatic logic [2:0] cmp_shift(input logic [MODE_W-1:0] mode);
    logic [2:0] r;
    r = 3'd0;
    unique case (mode)
      MODE_D1: r = 3'd1;
      MODE_D4: r = 3'd4;
      MODE_D5: r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Mask keeping the low d quotient bits
  function automatic logic [QUOT_W-1:0] cmp_mask(input logic [MODE_W-1:0] mode);
    logic [QUOT_W-1:0] r;
    r = '1;
    unique case (mode)
      MODE_D1: r = 5'h01;
      MODE_D4: r = 5'h0F;
      MODE_D5: r = 5'h1F;
      default: r = 5'h1F;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ccp_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_datapath
// Config registers, bit-serial rounding divider, bit packer, output register.
// ----------------------------------------------------------------------------
module ccp_datapath #(
  parameter int MODULUS_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write_en,
  input  wire logic [ccp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ccp_pkg::MODULUS_W-1:0]   cfg_data,
  input  wire logic signed [ccp_pkg::COEFF_W-1:0] coeff,
  input  wire logic                            last_coeff,
  input  wire logic                            out_stall,
  output logic                                 out_valid,
  output logic [ccp_pkg::BYTE_W-1:0]           out_byte,
  output logic                                 last_byte,
  input  wire ccp_pkg::dp_cmd_t                cmd,
  output ccp_pkg::dp_stat_t                    stat
);

  localparam int SUM_W = MODULUS_BITS + 2;
  localparam int NUM_W = MODULUS_BITS + 6;
  localparam int ACC_W = MODULUS_BITS + ccp_pkg::PEND_W;
  localparam int TOT_W = $clog2(ACC_W + 1);
  localparam int CNT_W = $clog2(NUM_W);
  localparam int Q_W   = ccp_pkg::MODULUS_W;

  logic [ccp_pkg::MODE_W-1:0] mode;
  logic [Q_W-1:0]             modulus;

  logic [MODULUS_BITS-1:0]    u_reg;
  logic [NUM_W-1:0]           num_sr;
  logic [Q_W-1:0]             rem;
  logic [ccp_pkg::QUOT_W-1:0] quot;
  logic [CNT_W-1:0]           step_cnt;
  logic                       last_reg;
  logic [ACC_W-1:0]           acc;
  logic [TOT_W-1:0]           total;
  logic [ccp_pkg::PEND_W-1:0] pending;
  logic [ccp_pkg::PCNT_W-1:0] pend_count;

  logic [SUM_W-1:0]           coeff_ext;
  logic [SUM_W-1:0]           sum;
  logic [MODULUS_BITS-1:0]    u_in;
  logic [2:0]                 d_shift;
  logic [NUM_W-1:0]           num_in;
  logic [Q_W:0]               rem_sh;
  logic [Q_W:0]               rem_diff;
  logic                       ge;
  logic                       raw;
  logic [MODULUS_BITS-1:0]    word;
  logic [TOT_W-1:0]           d_width;

  assign raw     = (mode == ccp_pkg::MODE_RAW);
  assign d_shift = ccp_pkg::cmp_shift(mode);
  assign d_width = raw ? TOT_W'(MODULUS_BITS) : TOT_W'(d_shift);

  // Fold negatives into range once, wrap to the word width
  assign coeff_ext = {{(SUM_W - ccp_pkg::COEFF_W){coeff[ccp_pkg::COEFF_W-1]}}, coeff};
  assign sum       = coeff_ext + (coeff[ccp_pkg::COEFF_W-1] ? SUM_W'(modulus) : '0);
  assign u_in      = sum[MODULUS_BITS-1:0];
  assign num_in    = (NUM_W'(u_in) << d_shift) + NUM_W'(modulus[Q_W-1:1]);

  // Restoring division step; a zero modulus yields all-ones quotient bits
  assign rem_sh   = {rem, num_sr[NUM_W-1]};
  assign ge       = (rem_sh >= {1'b0, modulus});
  assign rem_diff = rem_sh - {1'b0, modulus};

  assign word = raw ? u_reg : MODULUS_BITS'(quot & ccp_pkg::cmp_mask(mode));

  assign stat.raw_mode   = raw;
  assign stat.div_last   = (step_cnt == CNT_W'(NUM_W - 1));
  assign stat.byte_avail = (total >= TOT_W'(8)) || (last_reg && (total != '0));
  assign stat.out_free   = !out_valid || !out_stall;

  // Configuration and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= ccp_pkg::MODE_RESET;
      modulus    <= ccp_pkg::MODULUS_RESET;
      pending    <= '0;
      pend_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          ccp_pkg::REG_MODE:    mode    <= cfg_data[ccp_pkg::MODE_W-1:0];
          ccp_pkg::REG_MODULUS: modulus <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.finish) begin
        pending    <= last_reg ? '0 : acc[ccp_pkg::PEND_W-1:0];
        pend_count <= last_reg ? '0 : total[ccp_pkg::PCNT_W-1:0];
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u_reg    <= u_in;
      num_sr   <= num_in;
      rem      <= '0;
      quot     <= '0;
      step_cnt <= '0;
      last_reg <= last_coeff;
    end
    if (cmd.div_step) begin
      num_sr   <= num_sr << 1;
      rem      <= ge ? rem_diff[Q_W-1:0] : rem_sh[Q_W-1:0];
      quot     <= {quot[ccp_pkg::QUOT_W-2:0], ge};
      step_cnt <= step_cnt + 1'b1;
    end
    if (cmd.merge) begin
      acc   <= ACC_W'(pending) | (ACC_W'(word) << pend_count);
      total <= TOT_W'(pend_count) + d_width;
    end
    if (cmd.emit) begin
      out_byte  <= acc[ccp_pkg::BYTE_W-1:0];
      last_byte <= last_reg && (total <= TOT_W'(8));
      acc       <= acc >> ccp_pkg::BYTE_W;
      total     <= (total >= TOT_W'(8)) ? total - TOT_W'(8) : '0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ccp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_ctrl
// Sequencer: accept, divide (skipped in raw mode), merge, emit bytes, close the item.
// ----------------------------------------------------------------------------
module ccp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output ccp_pkg::dp_cmd_t        cmd,
  input  wire ccp_pkg::dp_stat_t  stat
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_MERGE = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.raw_mode ? S_MERGE : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_MERGE;
        end
      end
      S_MERGE: begin
        cmd.merge  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.byte_avail) begin
          cmd.emit = stat.out_free;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/coefficient_compress_pack.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// coefficient_compress_pack
// Compress polynomial coefficients and pack them into a little-endian bytes.
// ----------------------------------------------------------------------------
// One signed coefficient is taken per item. A negative value gets the modulus
// added once; the 1-, 4- and 5-bit modes then round u*2^d/q to the nearest
// integer and keep d bits, while the raw mode passes u as a MODULUS_BITS-wide
// word. Words go out least significant bit first; each finished byte is one
// output item, and the last coefficient zero-pads and flags the final byte.
// An item passes through the accept, the divider steps (skipped in raw mode),
// the merge, the emission of its bytes (held while the output stalls) and the
// close. The bit-serial restoring divider makes one quotient bit per cycle.
// A new item is taken while the last byte of the previous one still waits.
// ----------------------------------------------------------------------------
module coefficient_compress_pack #(
  parameter int MODULUS_BITS = 12
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration write port
  input  wire logic                               cfg_write_en,
  input  wire logic [ccp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ccp_pkg::MODULUS_W-1:0]      cfg_data,
  // coefficient items
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [ccp_pkg::COEFF_W-1:0] coeff,
  input  wire logic                               last_coeff,
  // byte items
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [ccp_pkg::BYTE_W-1:0]              out_byte,
  output logic                                    last_byte
);

  ccp_pkg::dp_cmd_t  cmd;
  ccp_pkg::dp_stat_t stat;

  // Sequencer: owns the input handshake and drives datapath commands
  ccp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Divider, packer and output register
  ccp_datapath #(
    .MODULUS_BITS (MODULUS_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .coeff        (coeff),
    .last_coeff   (last_coeff),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .last_byte    (last_byte),
    .cmd          (cmd),
    .stat         (stat)
  );

  // Hold off further items while one is in work
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while previous item in work");

  // Never overwrite a byte still waiting at the output
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("byte emitted over a stalled output");

  // At most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.div_step, cmd.merge, cmd.emit, cmd.finish}))
    else $error("conflicting datapath commands");

  // A load only happens when the input side is open
  a_load_open: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (in_valid && !in_stall))
    else $error("load without accepted item");

endmodule
`default_nettype wire
